@@ sv/ipv6_rx_checksum_classifier_unit_assert.svh @@
`ifndef IPV6_RX_CHECKSUM_CLASSIFIER_UNIT_ASSERT_SVH
`define IPV6_RX_CHECKSUM_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define IPV6RX_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPV6RX_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ipv6rx_pkg.sv @@
package ipv6rx_pkg;

	localparam int unsigned FRAME_COUNT_BITS_DEF = 17;
	localparam int unsigned HDR_BYTES = 40;

	localparam logic [7:0] NH_ICMP = 8'd58;
	localparam logic [7:0] NH_UDP = 8'd17;
	localparam logic [7:0] NH_TCP = 8'd6;

	localparam logic [7:0] ICMP_ERR_LO = 8'd1;
	localparam logic [7:0] ICMP_ERR_HI = 8'd4;
	localparam logic [7:0] ICMP_ECHO_REQ = 8'd128;
	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd129;
	localparam logic [7:0] ICMP_ND_LO = 8'd130;
	localparam logic [7:0] ICMP_ND_HI = 8'd136;
	localparam logic [7:0] ICMP_MLD2_REPORT = 8'd143;

	localparam logic [15:0] CSUM_GOOD = 16'hFFFF;
	localparam logic [15:0] REPLY_TYPE_WORD = 16'h8100;
	localparam logic [15:0] ICMP_MIN_LEN = 16'd8;

	typedef enum logic [3:0] {
		V_SHORT      = 4'd0,
		V_BAD_VER    = 4'd1,
		V_TRUNC      = 4'd2,
		V_ICMP_EMPTY = 4'd3,
		V_BAD_CSUM   = 4'd4,
		V_ND_MLD     = 4'd5,
		V_ECHO_REQ   = 4'd6,
		V_ECHO_REPLY = 4'd7,
		V_ICMP_ERR   = 4'd8,
		V_ICMP_OTHER = 4'd9,
		V_UDP        = 4'd10,
		V_TCP        = 4'd11,
		V_OTHER      = 4'd12
	} verdict_t;

	typedef struct packed {
		logic [31:0] icmp_error_total;
		logic [31:0] echo_reply_total;
		logic [15:0] reply_checksum;
		logic [15:0] payload_length;
		logic [7:0]  icmp_type;
		logic [7:0]  nxt_hdr;
		verdict_t    verdict;
	} result_t;

	// ones' complement add, end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ sv/ipv6rx_frame_parse.sv @@
module ipv6rx_frame_parse #(
	parameter int unsigned FRAME_COUNT_BITS = ipv6rx_pkg::FRAME_COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output ipv6rx_pkg::result_t result
);
	import ipv6rx_pkg::*;

	localparam int unsigned SizeBits = FRAME_COUNT_BITS + 1;
	localparam logic [FRAME_COUNT_BITS-1:0] IdxMax = '1;
	localparam logic [FRAME_COUNT_BITS-1:0] IdxHdr = FRAME_COUNT_BITS'(HDR_BYTES);

	logic [FRAME_COUNT_BITS-1:0] idx_q;
	logic [15:0] sum_q, rsum_q, plen_q;
	logic [7:0]  pend_q, nh_q, type_q;
	logic        ver_ok_q;
	logic [31:0] echo_cnt_q, err_cnt_q;

	logic [15:0] sum_n, rsum_n, plen_n, word, pad, pad_reply, sum_f, rsum_f, reply_ck;
	logic [7:0]  pend_n, nh_n, type_n, type_out;
	logic        ver_ok_n, in_hdr_addr, in_payload, echo_inc, err_inc;
	logic [FRAME_COUNT_BITS-1:0] off;
	logic [SizeBits-1:0] size, need;
	verdict_t verdict;

	always_comb begin
		sum_n = sum_q;
		rsum_n = rsum_q;
		plen_n = plen_q;
		pend_n = pend_q;
		nh_n = nh_q;
		type_n = type_q;
		ver_ok_n = ver_ok_q;
		word = {pend_q, data_byte};
		off = idx_q - IdxHdr;
		in_hdr_addr = (idx_q >= FRAME_COUNT_BITS'(8)) && (idx_q < IdxHdr);
		in_payload = (idx_q >= IdxHdr) && (off < FRAME_COUNT_BITS'(plen_q));

		if (idx_q == FRAME_COUNT_BITS'(0)) begin
			ver_ok_n = (data_byte[7:4] == 4'd6);
		end else if (idx_q == FRAME_COUNT_BITS'(4)) begin
			plen_n = {data_byte, 8'h00};
		end else if (idx_q == FRAME_COUNT_BITS'(5)) begin
			plen_n = {plen_q[15:8], data_byte};
			sum_n = oc_add(oc_add(sum_q, plen_n), {8'h00, NH_ICMP});
			rsum_n = oc_add(oc_add(rsum_q, plen_n), {8'h00, NH_ICMP});
		end else if (idx_q == FRAME_COUNT_BITS'(6)) begin
			nh_n = data_byte;
		end else if (in_hdr_addr) begin
			if (!idx_q[0]) begin
				pend_n = data_byte;
			end else begin
				sum_n = oc_add(sum_q, word);
				rsum_n = oc_add(rsum_q, word);
			end
		end else if (in_payload) begin
			if (off == FRAME_COUNT_BITS'(0))
				type_n = data_byte;
			if (!idx_q[0]) begin
				pend_n = data_byte;
			end else begin
				sum_n = oc_add(sum_q, word);
				// type/code replaced, checksum field zeroed
				if (off < FRAME_COUNT_BITS'(2))
					rsum_n = oc_add(rsum_q, REPLY_TYPE_WORD);
				else if (off < FRAME_COUNT_BITS'(4))
					rsum_n = rsum_q;
				else
					rsum_n = oc_add(rsum_q, word);
			end
		end

		// odd payload: pad final byte with zero
		pad = {pend_n, 8'h00};
		if (plen_n == 16'd1)
			pad_reply = REPLY_TYPE_WORD;
		else if (plen_n == 16'd3)
			pad_reply = 16'h0000;
		else
			pad_reply = pad;
		sum_f = plen_n[0] ? oc_add(sum_n, pad) : sum_n;
		rsum_f = plen_n[0] ? oc_add(rsum_n, pad_reply) : rsum_n;

		size = SizeBits'(idx_q) + SizeBits'(1);
		need = SizeBits'(plen_n) + SizeBits'(HDR_BYTES);
		type_out = 8'h00;
		reply_ck = 16'h0000;
		echo_inc = 1'b0;
		err_inc = 1'b0;

		if (size < SizeBits'(HDR_BYTES)) begin
			verdict = V_SHORT;
		end else if (!ver_ok_n) begin
			verdict = V_BAD_VER;
		end else if (need > size) begin
			verdict = V_TRUNC;
		end else if (nh_n == NH_ICMP) begin
			type_out = type_n;
			if (plen_n == 16'd0) begin
				verdict = V_ICMP_EMPTY;
			end else if (sum_f != CSUM_GOOD) begin
				verdict = V_BAD_CSUM;
			end else if ((type_n >= ICMP_ND_LO && type_n <= ICMP_ND_HI) ||
					type_n == ICMP_MLD2_REPORT) begin
				verdict = V_ND_MLD;
			end else if (plen_n < ICMP_MIN_LEN) begin
				verdict = V_ICMP_OTHER;
			end else if (type_n == ICMP_ECHO_REQ) begin
				verdict = V_ECHO_REQ;
				reply_ck = ~rsum_f;
			end else if (type_n == ICMP_ECHO_REPLY) begin
				verdict = V_ECHO_REPLY;
				echo_inc = 1'b1;
			end else if (type_n >= ICMP_ERR_LO && type_n <= ICMP_ERR_HI) begin
				verdict = V_ICMP_ERR;
				err_inc = 1'b1;
			end else begin
				verdict = V_ICMP_OTHER;
			end
		end else if (nh_n == NH_UDP) begin
			verdict = V_UDP;
		end else if (nh_n == NH_TCP) begin
			verdict = V_TCP;
		end else begin
			verdict = V_OTHER;
		end

		result.verdict = verdict;
		result.nxt_hdr = nh_n;
		result.icmp_type = type_out;
		result.payload_length = plen_n;
		result.reply_checksum = reply_ck;
		result.echo_reply_total = echo_cnt_q + {31'd0, echo_inc};
		result.icmp_error_total = err_cnt_q + {31'd0, err_inc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			rsum_q <= '0;
			plen_q <= '0;
			pend_q <= '0;
			nh_q <= '0;
			type_q <= '0;
			ver_ok_q <= 1'b0;
			echo_cnt_q <= '0;
			err_cnt_q <= '0;
		end else if (advance) begin
			if (last_byte) begin
				idx_q <= '0;
				sum_q <= '0;
				rsum_q <= '0;
				plen_q <= '0;
				pend_q <= '0;
				nh_q <= '0;
				type_q <= '0;
				ver_ok_q <= 1'b0;
				echo_cnt_q <= result.echo_reply_total;
				err_cnt_q <= result.icmp_error_total;
			end else begin
				if (idx_q != IdxMax)
					idx_q <= idx_q + FRAME_COUNT_BITS'(1);
				sum_q <= sum_n;
				rsum_q <= rsum_n;
				plen_q <= plen_n;
				pend_q <= pend_n;
				nh_q <= nh_n;
				type_q <= type_n;
				ver_ok_q <= ver_ok_n;
			end
		end
	end

endmodule

@@ sv/ipv6_rx_checksum_classifier_unit.sv @@
// IPv6 receive classifier: takes a frame one byte per transaction on s_axis (tlast on
// the final byte) and returns one 116-bit result per frame on m_axis: verdict, next
// header, ICMPv6 type, payload length, echo reply checksum and the two running
// counters. One byte is taken every cycle unless the input stalls; the final byte is
// held in the input stage register, then its result in the output register. Throughput
// is set by the per-byte ones' complement adder into the running checksum. Input stalls
// only when a finished result has not been taken and another final byte is waiting.
`include "ipv6_rx_checksum_classifier_unit_assert.svh"

module ipv6_rx_checksum_classifier_unit #(
	parameter int unsigned FRAME_COUNT_BITS = ipv6rx_pkg::FRAME_COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// verdict, nxt_hdr, icmp_type, payload_length, reply_checksum,
	// echo_reply_total, icmp_error_total, zero fill
	output logic [119:0] m_axis_tdata
);
	import ipv6rx_pkg::*;

	logic       s1_valid_q;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance, load_out;
	logic       out_valid_q;
	result_t    result, out_q;

	assign advance = s1_valid_q && (!last_s1 || !out_valid_q || m_axis_tready);
	assign load_out = advance && last_s1;
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ipv6rx_frame_parse #(
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'h0, out_q};

	`IPV6RX_ASSERT_NOW(a_ready_when_empty, !s1_valid_q, s_axis_tready, "input stage empty but not ready")
	`IPV6RX_ASSERT_NOW(a_no_overwrite, out_valid_q && !m_axis_tready, !load_out, "pending result overwritten")
	`IPV6RX_ASSERT_NEXT(a_result_held, out_valid_q && !m_axis_tready, out_valid_q, "pending result dropped")
	`IPV6RX_ASSERT_NOW(a_reply_ck_only_echo, out_valid_q && out_q.verdict != V_ECHO_REQ, out_q.reply_checksum == 16'h0000, "reply checksum on non echo request")

endmodule

@@ dv/tb_ipv6_rx_checksum_classifier_unit.sv @@
module tb_ipv6_rx_checksum_classifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv6rx_pkg::*;

	localparam int unsigned FCB = FRAME_COUNT_BITS_DEF;
	localparam int unsigned IDX_MAX = (1 << FCB) - 1;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		verdict_t    verdict;
		logic [7:0]  nxt_hdr;
		logic [7:0]  icmp_type;
		logic [15:0] payload_length;
		logic [15:0] reply_checksum;
		logic [31:0] echo_reply_total;
		logic [31:0] icmp_error_total;
	} frame_report_t;

	// end-around carry add of two 16-bit words
	function automatic logic [15:0] csum_fold(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] t;
		t = {16'd0, a} + {16'd0, b};
		t = (t & 32'h0000_ffff) + (t >> 16);
		return t[15:0];
	endfunction

	class ipv6_frame_scoreboard;
		logic [FCB-1:0] byte_idx;
		logic [15:0]    sum_acc;
		logic [15:0]    reply_acc;
		logic [7:0]     pend;
		bit             ver_ok;
		logic [15:0]    plen_r;
		logic [7:0]     nh_r;
		logic [7:0]     type_r;
		logic [31:0]    echo_reply_cnt;
		logic [31:0]    icmp_err_cnt;
		frame_report_t  expected_q[$];
		int             errors;
		int             verdict_hits[16];

		function new();
			clear_frame();
			echo_reply_cnt = '0;
			icmp_err_cnt = '0;
			errors = 0;
			foreach (verdict_hits[i])
				verdict_hits[i] = 0;
		endfunction

		function void clear_frame();
			byte_idx = '0;
			sum_acc = '0;
			reply_acc = '0;
			pend = '0;
			ver_ok = 1'b0;
			plen_r = '0;
			nh_r = '0;
			type_r = '0;
		endfunction

		function void add_both(input logic [15:0] v);
			sum_acc = csum_fold(sum_acc, v);
			reply_acc = csum_fold(reply_acc, v);
		endfunction

		// reply carries type 129 code 0 and a zero checksum field
		function logic [15:0] reply_term(input int unsigned off, input logic [15:0] word);
			if (off < 2)
				return REPLY_TYPE_WORD;
			if (off < 4)
				return 16'h0000;
			return word;
		endfunction

		function void take_byte(input logic [7:0] b, input logic last);
			int unsigned   idx;
			int unsigned   off;
			int unsigned   size;
			logic [15:0]   word;
			logic [15:0]   pad;
			frame_report_t r;
			idx = byte_idx;
			if (idx == 0) begin
				ver_ok = (b[7:4] == 4'd6);
			end else if (idx == 4) begin
				plen_r = {b, 8'h00};
			end else if (idx == 5) begin
				plen_r[7:0] = b;
				add_both(plen_r);
				add_both({8'h00, NH_ICMP});
			end else if (idx == 6) begin
				nh_r = b;
			end else if (idx >= 8 && idx < HDR_BYTES) begin
				if (idx[0] == 1'b0)
					pend = b;
				else
					add_both({pend, b});
			end else if (idx >= HDR_BYTES && idx - HDR_BYTES < plen_r) begin
				off = idx - HDR_BYTES;
				if (off == 0)
					type_r = b;
				if (off[0] == 1'b0) begin
					pend = b;
				end else begin
					word = {pend, b};
					sum_acc = csum_fold(sum_acc, word);
					reply_acc = csum_fold(reply_acc, reply_term(off, word));
				end
			end

			if (!last) begin
				if (idx < IDX_MAX)
					byte_idx = byte_idx + 1'b1;
				return;
			end

			size = idx + 1;
			r.nxt_hdr = nh_r;
			r.payload_length = plen_r;
			r.icmp_type = 8'h00;
			r.reply_checksum = 16'h0000;
			if (size < HDR_BYTES) begin
				r.verdict = V_SHORT;
			end else if (!ver_ok) begin
				r.verdict = V_BAD_VER;
			end else if (int'(plen_r) + HDR_BYTES > size) begin
				r.verdict = V_TRUNC;
			end else if (nh_r == NH_ICMP) begin
				r.icmp_type = type_r;
				if (plen_r == 16'd0) begin
					r.verdict = V_ICMP_EMPTY;
				end else begin
					if (plen_r[0]) begin
						pad = {pend, 8'h00};
						sum_acc = csum_fold(sum_acc, pad);
						reply_acc = csum_fold(reply_acc, reply_term(plen_r - 1, pad));
					end
					if (sum_acc != CSUM_GOOD) begin
						r.verdict = V_BAD_CSUM;
					end else if ((type_r >= ICMP_ND_LO && type_r <= ICMP_ND_HI) ||
					             type_r == ICMP_MLD2_REPORT) begin
						r.verdict = V_ND_MLD;
					end else if (plen_r < ICMP_MIN_LEN) begin
						r.verdict = V_ICMP_OTHER;
					end else if (type_r == ICMP_ECHO_REQ) begin
						r.verdict = V_ECHO_REQ;
						r.reply_checksum = ~reply_acc;
					end else if (type_r == ICMP_ECHO_REPLY) begin
						r.verdict = V_ECHO_REPLY;
						echo_reply_cnt = echo_reply_cnt + 1;
					end else if (type_r >= ICMP_ERR_LO && type_r <= ICMP_ERR_HI) begin
						r.verdict = V_ICMP_ERR;
						icmp_err_cnt = icmp_err_cnt + 1;
					end else begin
						r.verdict = V_ICMP_OTHER;
					end
				end
			end else if (nh_r == NH_UDP) begin
				r.verdict = V_UDP;
			end else if (nh_r == NH_TCP) begin
				r.verdict = V_TCP;
			end else begin
				r.verdict = V_OTHER;
			end
			r.echo_reply_total = echo_reply_cnt;
			r.icmp_error_total = icmp_err_cnt;
			expected_q.push_back(r);
			clear_frame();
		endfunction

		function void check_field(input string name, input logic [31:0] exp,
		                          input logic [31:0] act);
			if (act !== exp) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_report(input logic [119:0] d);
			frame_report_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no frame pending, expected none, got %h", $time, d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			verdict_hits[e.verdict]++;
			check_field("verdict", 32'(e.verdict), {28'd0, d[3:0]});
			check_field("nxt_hdr", {24'd0, e.nxt_hdr}, {24'd0, d[11:4]});
			check_field("icmp_type", {24'd0, e.icmp_type}, {24'd0, d[19:12]});
			check_field("payload_length", {16'd0, e.payload_length}, {16'd0, d[35:20]});
			check_field("reply_checksum", {16'd0, e.reply_checksum}, {16'd0, d[51:36]});
			check_field("echo_reply_total", e.echo_reply_total, d[83:52]);
			check_field("icmp_error_total", e.icmp_error_total, d[115:84]);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;

	ipv6_frame_scoreboard sb;
	logic [7:0]  frame_q[$];
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned longest_frame = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_hold = 0;
	logic [15:0] rx_cycle = '0;

	always #6 clk = ~clk;

	ipv6_rx_checksum_classifier_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// receiver: free running, light random stalls, long rare stalls, alternating ready
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_cycle[10:9])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: begin
					if ($urandom_range(0, 2) == 0) begin
						rx_hold = $urandom_range(0, 3);
						m_axis_tready <= 1'b0;
					end else begin
						m_axis_tready <= 1'b1;
					end
				end
				2'd2: begin
					if ($urandom_range(0, 15) == 0) begin
						rx_hold = $urandom_range(5, 30);
						m_axis_tready <= 1'b0;
					end else begin
						m_axis_tready <= 1'b1;
					end
				end
				default: m_axis_tready <= rx_cycle[0];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_report(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_byte(b, last);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			push_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
		if (frame_q.size() > longest_frame)
			longest_frame = frame_q.size();
	endtask

	// header, payload and optional tail; extra < 0 cuts the frame short
	task automatic run_frame(input logic [3:0] ver, input int plen, input logic [7:0] nh,
	                         input logic [7:0] itype, input int extra, input bit fix);
		int          i;
		int          keep;
		logic [15:0] s;
		logic [15:0] w;
		logic [15:0] pl;
		pl = 16'(plen);
		frame_q.delete();
		frame_q.push_back({ver, 4'($urandom_range(0, 15))});
		repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(pl[15:8]);
		frame_q.push_back(pl[7:0]);
		frame_q.push_back(nh);
		frame_q.push_back(8'($urandom_range(0, 255)));
		for (i = 8; i < HDR_BYTES; i++)
			frame_q.push_back(8'($urandom_range(0, 255)));
		for (i = 0; i < plen; i++)
			frame_q.push_back((i == 0) ? itype : 8'($urandom_range(0, 255)));
		if (fix) begin
			// last address word absorbs the sum so the frame checks good
			frame_q[38] = 8'h00;
			frame_q[39] = 8'h00;
			s = csum_fold(16'h0000, pl);
			s = csum_fold(s, {8'h00, NH_ICMP});
			for (i = 8; i < HDR_BYTES; i += 2)
				s = csum_fold(s, {frame_q[i], frame_q[i + 1]});
			for (i = 0; i < plen; i += 2)
				s = csum_fold(s, {frame_q[HDR_BYTES + i],
				                  (i + 1 < plen) ? frame_q[HDR_BYTES + i + 1] : 8'h00});
			w = ~s;
			frame_q[38] = w[15:8];
			frame_q[39] = w[7:0];
		end
		if (extra > 0) begin
			repeat (extra) frame_q.push_back(8'($urandom_range(0, 255)));
		end else if (extra < 0) begin
			keep = int'(HDR_BYTES) + plen + extra;
			if (keep < 1)
				keep = 1;
			while (frame_q.size() > keep)
				void'(frame_q.pop_back());
		end
		send_frame();
	endtask

	function automatic logic [7:0] pick_icmp_type();
		case ($urandom_range(0, 7))
			0: return ICMP_ECHO_REQ;
			1: return ICMP_ECHO_REPLY;
			2: return 8'($urandom_range(ICMP_ERR_LO, ICMP_ERR_HI));
			3: return 8'($urandom_range(ICMP_ND_LO, ICMP_ND_HI));
			4: return ICMP_MLD2_REPORT;
			5: return ICMP_ECHO_REQ;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int          sel;
		int          plen;
		int          kinds;
		logic [3:0]  ver;
		logic [7:0]  nh;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed
		run_frame(4'd6, 0, NH_ICMP, ICMP_ECHO_REQ, -39, 1'b0);
		run_frame(4'd6, 0, NH_ICMP, ICMP_ECHO_REQ, -1, 1'b0);
		run_frame(4'd4, 8, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b1);
		run_frame(4'd6, 20, NH_ICMP, ICMP_ECHO_REQ, -10, 1'b1);
		run_frame(4'd6, 0, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b0);
		run_frame(4'd6, 8, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b0);
		run_frame(4'd6, 24, NH_ICMP, ICMP_ND_LO, 0, 1'b1);
		run_frame(4'd6, 24, NH_ICMP, ICMP_ND_HI, 0, 1'b1);
		run_frame(4'd6, 24, NH_ICMP, ICMP_MLD2_REPORT, 0, 1'b1);
		run_frame(4'd6, 1, NH_ICMP, ICMP_ND_HI - 8'd1, 0, 1'b1);
		run_frame(4'd6, 8, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b1);
		run_frame(4'd6, 9, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b1);
		run_frame(4'd6, 64, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b1);
		run_frame(4'd6, 8, NH_ICMP, ICMP_ECHO_REPLY, 0, 1'b1);
		run_frame(4'd6, 8, NH_ICMP, ICMP_ERR_LO, 0, 1'b1);
		run_frame(4'd6, 11, NH_ICMP, ICMP_ERR_HI, 0, 1'b1);
		run_frame(4'd6, 8, NH_ICMP, 8'h00, 0, 1'b1);
		run_frame(4'd6, 8, NH_ICMP, 8'hff, 0, 1'b1);
		run_frame(4'd6, 4, NH_ICMP, ICMP_ECHO_REQ, 0, 1'b1);
		run_frame(4'd6, 7, NH_ICMP, ICMP_ECHO_REPLY, 0, 1'b1);
		run_frame(4'd6, 16, NH_UDP, 8'h00, 0, 1'b0);
		run_frame(4'd6, 16, NH_TCP, 8'h00, 0, 1'b0);
		run_frame(4'd6, 16, 8'hff, 8'h00, 0, 1'b0);
		run_frame(4'd6, 8, NH_ICMP, ICMP_ECHO_REQ, 30, 1'b1);

		// random
		while (bytes_sent < 1800) begin
			sel = $urandom_range(0, 99);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
			if (sel < 70) begin
				run_frame(4'd6, plen, NH_ICMP, pick_icmp_type(),
				          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0,
				          $urandom_range(0, 9) != 0);
			end else if (sel < 80) begin
				case ($urandom_range(0, 2))
					0: nh = NH_UDP;
					1: nh = NH_TCP;
					default: nh = 8'($urandom_range(0, 255));
				endcase
				run_frame(4'd6, plen, nh, 8'($urandom_range(0, 255)),
				          $urandom_range(0, 4), 1'b0);
			end else if (sel < 90) begin
				case ($urandom_range(0, 3))
					0: run_frame(4'd6, plen, NH_ICMP, pick_icmp_type(),
					             -int'($urandom_range(1, plen)), 1'b1);
					1: run_frame(4'd6, plen, NH_ICMP, pick_icmp_type(),
					             int'($urandom_range(1, 39)) - int'(HDR_BYTES) - plen, 1'b1);
					2: begin
						ver = 4'($urandom_range(0, 15));
						if (ver == 4'd6)
							ver = 4'd7;
						run_frame(ver, plen, NH_ICMP, pick_icmp_type(), 0, 1'b1);
					end
					default: run_frame(4'd6, 0, NH_ICMP, 8'h00, $urandom_range(0, 10), 1'b0);
				endcase
			end else begin
				frame_q.delete();
				repeat ($urandom_range(1, 80)) frame_q.push_back(8'($urandom_range(0, 255)));
				send_frame();
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		kinds = 0;
		foreach (sb.verdict_hits[i])
			if (sb.verdict_hits[i] > 0)
				kinds++;
		$display("Ran %0d frames, %0d bytes, longest %0d bytes, bursty input, stalled output",
		         frames_sent, bytes_sent, longest_frame);
		$display("Hit %0d verdict kinds; %0d echo replies and %0d ICMPv6 errors counted",
		         kinds, sb.echo_reply_cnt, sb.icmp_err_cnt);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
